// ----- hw/rtl/ogp_pkg.sv -----
// Shared types and constants for the Ogg page header parser.
package ogp_pkg;

  // Result kinds carried on m_tuser
  localparam logic [1:0] KIND_PACKET = 2'd0;
  localparam logic [1:0] KIND_DONE   = 2'd1;
  localparam logic [1:0] KIND_SYNC   = 2'd2;

  // Header layout
  localparam logic [7:0] LACE_CONTINUE = 8'd255;
  localparam logic [8:0] FIXED_HEADER  = 9'd27;
  localparam logic [8:0] OFFSET_TYPE   = 9'd5;
  localparam logic [8:0] OFFSET_SEGS   = 9'd26;
  localparam logic [8:0] OFFSET_MAX    = 9'h1FF;

  // Capture pattern "OggS", entry 0 is the first byte
  localparam logic [3:0][7:0] CAPTURE_PATTERN = {8'h53, 8'h67, 8'h67, 8'h4F};

  // Output tdata width: 60 payload bits padded to whole bytes
  localparam int unsigned RES_DATA_W = 64;

  // One result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] packet_length;
    logic [7:0]  packet_index;
    logic [15:0] page_total_length;
    logic [7:0]  packet_count;
    logic        continued_flag;
    logic        first_page_flag;
    logic        last_page_flag;
    logic [8:0]  header_size;
    logic        last;
  } res_t;

  // Results produced by one byte, handed from parser core to result queue
  typedef struct packed {
    logic [1:0] num;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

// ----- hw/rtl/ogp_core.sv -----
// Parser state and per-byte decode of the Ogg page header.
module ogp_core
  import ogp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic       page_start,
  input  logic [7:0] data_byte,
  output push_t      push
);

  logic [8:0]  byte_offset, byte_offset_next;
  logic        hunting, hunting_next;
  logic [2:0]  type_bits, type_bits_next;
  logic [7:0]  segment_count, segment_count_next;
  logic [15:0] packet_accum, packet_accum_next;
  logic [7:0]  entry_count, entry_count_next;
  logic [15:0] total_bytes, total_bytes_next;

  // page_start restarts the header from clean state
  logic [8:0]  off_e;
  logic [2:0]  type_e;
  logic [7:0]  seg_e;
  logic [15:0] accum_e;
  logic [7:0]  entry_e;
  logic [15:0] total_e;
  logic [15:0] accum_sum;
  logic [15:0] total_sum;
  logic        is_cont;
  logic        tbl_end;
  logic        pkt;
  logic [7:0]  entry_after;
  res_t        pkt_res;
  res_t        done_res;
  res_t        sync_res;

  always_comb begin
    off_e   = page_start ? 9'd0  : byte_offset;
    type_e  = page_start ? 3'd0  : type_bits;
    seg_e   = page_start ? 8'd0  : segment_count;
    accum_e = page_start ? 16'd0 : packet_accum;
    entry_e = page_start ? 8'd0  : entry_count;
    total_e = page_start ? 16'd0 : total_bytes;

    accum_sum   = accum_e + {8'd0, data_byte};
    total_sum   = total_e + {8'd0, data_byte};
    is_cont     = (data_byte == LACE_CONTINUE);
    tbl_end     = ({1'b0, off_e} + 10'd1) >= ({1'b0, FIXED_HEADER} + {2'b00, seg_e});
    pkt         = !is_cont || tbl_end;
    entry_after = pkt ? entry_e + 8'd1 : entry_e;

    // packet entry result
    pkt_res               = '0;
    pkt_res.kind          = KIND_PACKET;
    pkt_res.packet_length = accum_sum;
    pkt_res.packet_index  = entry_e;
    pkt_res.last          = !tbl_end;

    // header done result; segment count and totals taken after this byte
    done_res                   = '0;
    done_res.kind              = KIND_DONE;
    done_res.page_total_length = (off_e == OFFSET_SEGS) ? 16'd0 : total_sum;
    done_res.packet_count      = (off_e == OFFSET_SEGS) ? 8'd0 : entry_after;
    done_res.continued_flag    = type_e[0];
    done_res.first_page_flag   = type_e[1];
    done_res.last_page_flag    = type_e[2];
    done_res.header_size       = FIXED_HEADER + ((off_e == OFFSET_SEGS) ?
                                 {1'b0, data_byte} : {1'b0, seg_e});
    done_res.last              = 1'b1;

    sync_res      = '0;
    sync_res.kind = KIND_SYNC;
    sync_res.last = 1'b1;
  end

  // next state and results of one accepted byte
  always_comb begin
    byte_offset_next   = byte_offset;
    hunting_next       = hunting;
    type_bits_next     = type_bits;
    segment_count_next = segment_count;
    packet_accum_next  = packet_accum;
    entry_count_next   = entry_count;
    total_bytes_next   = total_bytes;
    push               = '0;

    if (fire && (page_start || !hunting)) begin
      hunting_next       = 1'b0;
      type_bits_next     = type_e;
      segment_count_next = seg_e;
      packet_accum_next  = accum_e;
      entry_count_next   = entry_e;
      total_bytes_next   = total_e;
      byte_offset_next   = (off_e == OFFSET_MAX) ? off_e : off_e + 9'd1;

      if (off_e < 9'd4) begin
        // capture pattern check
        if (data_byte != CAPTURE_PATTERN[off_e[1:0]]) begin
          push.num     = 2'd1;
          push.r0      = sync_res;
          hunting_next = 1'b1;
        end
      end else if (off_e == OFFSET_TYPE) begin
        type_bits_next = data_byte[2:0];
      end else if (off_e == OFFSET_SEGS) begin
        segment_count_next = data_byte;
        if (data_byte == 8'd0) begin
          push.num     = 2'd1;
          push.r0      = done_res;
          hunting_next = 1'b1;
        end
      end else if (off_e > OFFSET_SEGS) begin
        // lacing table byte
        total_bytes_next  = total_sum;
        packet_accum_next = pkt ? 16'd0 : accum_sum;
        entry_count_next  = entry_after;
        if (pkt && tbl_end) begin
          push.num = 2'd2;
          push.r0  = pkt_res;
          push.r1  = done_res;
        end else if (pkt) begin
          push.num = 2'd1;
          push.r0  = pkt_res;
        end else if (tbl_end) begin
          push.num = 2'd1;
          push.r0  = done_res;
        end
        if (tbl_end) begin
          hunting_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset   <= '0;
      hunting       <= 1'b1;
      type_bits     <= '0;
      segment_count <= '0;
      packet_accum  <= '0;
      entry_count   <= '0;
      total_bytes   <= '0;
    end else begin
      byte_offset   <= byte_offset_next;
      hunting       <= hunting_next;
      type_bits     <= type_bits_next;
      segment_count <= segment_count_next;
      packet_accum  <= packet_accum_next;
      entry_count   <= entry_count_next;
      total_bytes   <= total_bytes_next;
    end
  end

endmodule

// ----- hw/rtl/ogp_out_fifo.sv -----
// Four-entry result queue, takes up to two results per cycle, emits one.
module ogp_out_fifo
  import ogp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  output logic  space_ok,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_res
);

  res_t       mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 3'd0);
  assign out_res   = mem[rd_ptr];
  // room for the worst case of two results from one byte
  assign space_ok  = (count <= 3'd2);

  // storage
  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.num == 2'd2) begin
      mem[wr_ptr + 2'd1] <= push.r1;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push.num;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count + {1'b0, push.num} - {2'b00, pop};
    end
  end

endmodule

// ----- hw/rtl/ogg_page_header_parser.sv -----
// Top level of the Ogg page header parser: input register, parser core, result queue.
//
// Feed one header byte per beat with tuser high on byte 0 of each page. Bytes
// are taken at one per cycle while the queue has room: each beat waits in the
// input register, where the parser core decodes it and writes its results into
// a four-entry queue. A byte gives zero, one or two results; the byte that
// ends the lacing table with a packet closed gives a packet entry then the
// header-done result. The queue drains one result per cycle while m_tready
// is high, so input runs at one byte per cycle as long as results are taken
// at least as fast as they are made. Sync errors and header-done results
// always have tlast set, and bytes seen while waiting for a page start give
// nothing.
module ogg_page_header_parser
  import ogp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // data_byte
  input  logic                  s_tuser,   // page_start
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // packet_length[15:0], packet_index[23:16], page_total_length[39:24],
  // packet_count[47:40], continued_flag[48], first_page_flag[49],
  // last_page_flag[50], header_size[59:51], zero[63:60]
  output logic [RES_DATA_W-1:0] m_tdata,
  output logic [1:0]            m_tuser,   // kind
  output logic                  m_tlast    // last
);

  logic       in_valid;
  logic       in_start;
  logic [7:0] in_byte;
  logic       space_ok;
  logic       fire;
  push_t      push;
  res_t       out_res;

  assign fire     = in_valid && space_ok;
  assign s_tready = !in_valid || space_ok;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_start <= s_tuser;
      in_byte  <= s_tdata;
    end
  end

  ogp_core u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .page_start (in_start),
    .data_byte  (in_byte),
    .push       (push)
  );

  ogp_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space_ok  (space_ok),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  // result packing
  assign m_tdata = {4'd0, out_res.header_size, out_res.last_page_flag,
                    out_res.first_page_flag, out_res.continued_flag,
                    out_res.packet_count, out_res.page_total_length,
                    out_res.packet_index, out_res.packet_length};
  assign m_tuser = out_res.kind;
  assign m_tlast = out_res.last;

  // checks
  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    (push.num != 2'd0) |=> m_tvalid)
    else $error("queued result not presented");

  a_sync_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_SYNC)) |-> (m_tlast && (m_tdata == '0)))
    else $error("sync error result malformed");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_DONE)) |-> (m_tlast && (m_tdata[59:51] >= 9'd27)))
    else $error("header done result malformed");

  a_held_byte: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !fire) |=> (in_valid && $stable(in_byte) && $stable(in_start)))
    else $error("stalled input byte lost");

endmodule
